/* hdl/mep_pkg.sv */
// Shared types and constants of the Mandelbrot escape-time pixel block.
package mep_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register field widths
    localparam int CENTER_W = 32;
    localparam int SPAN_W   = 31;
    localparam int DIM_W    = 13;

    // Register reset values
    localparam logic [CENTER_W-1:0] CENTER_RESET = '0;
    localparam logic [SPAN_W-1:0]   SPAN_X_RESET = 31'd65536;
    localparam logic [SPAN_W-1:0]   SPAN_Y_RESET = 31'd49152;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd800;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd600;

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Iteration datapath, signed Q6.24
    localparam int Z_W    = 30;
    localparam int Z_FRAC = 24;

    // Plane coordinate clamp: beyond this, c saturates regardless
    localparam int X_LIM  = 3145729;
    localparam int XC_W   = 24;

    // Q16.16 to Q6.24 and divide by 6 is times 128 / 3
    localparam int X_TO_C_SHIFT = 7;
    localparam int RECIP_BIAS   = 2;
    localparam int N_W          = XC_W + X_TO_C_SHIFT;
    localparam int RECIP_SHIFT  = 31;
    localparam int Q_W          = 29;
    localparam logic [MUL_W-1:0] RECIP_MUL = 32'h2AAA_AAAB;

    localparam logic signed [Z_W-1:0] C_HI = 30'sd134217728;
    localparam logic signed [Z_W-1:0] C_LO = -30'sd134217728;

    // |z|^2 > 16 in Q16.48
    localparam logic signed [PROD_W-1:0] ESC_BOUND = 64'sd4503599627370496;

    // Result fields
    localparam int ESC_W = 4;
    localparam int RED_W = 8;
    localparam logic [RED_W-1:0] RED_MAX = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_SPAN_X       = 3'd2,
        REG_SPAN_Y       = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [SPAN_W-1:0]   span_x;
        logic [SPAN_W-1:0]   span_y;
        logic [DIM_W-1:0]    image_width;
        logic [DIM_W-1:0]    image_height;
    } cfg_t;

endpackage

/* hdl/mep_cfg.sv */
// Viewport configuration registers with plain write port.
module mep_cfg
    import mep_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CENTER_X:     cfg_next.center_x     = cfg_wdata[CENTER_W-1:0];
                REG_CENTER_Y:     cfg_next.center_y     = cfg_wdata[CENTER_W-1:0];
                REG_SPAN_X:       cfg_next.span_x       = cfg_wdata[SPAN_W-1:0];
                REG_SPAN_Y:       cfg_next.span_y       = cfg_wdata[SPAN_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wdata[DIM_W-1:0];
                // drop writes past the register list
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= CENTER_RESET;
            cfg_reg.center_y     <= CENTER_RESET;
            cfg_reg.span_x       <= SPAN_X_RESET;
            cfg_reg.span_y       <= SPAN_Y_RESET;
            cfg_reg.image_width  <= WIDTH_RESET;
            cfg_reg.image_height <= HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mep_mul.sv */
// Shared signed multiplier with registered product.
module mep_mul
    import mep_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* hdl/mep_div.sv */
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module mep_div #(
    parameter int NUM_W = 45,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hdl/mandelbrot_escape_pixel.sv */
// Mandelbrot escape-time pixel evaluator: sequencer, mapping and iteration datapath.
//
// Pulse start while busy is low to hand in one pixel (pixel_x, pixel_y); the
// block maps it onto the configured viewport, runs z = z*z + c from zero and
// strobes done for one cycle with escape_index and red_level. The receiver
// cannot stall, so take the result in that cycle. Most of the work is the
// bit-serial divider that maps each axis, one quotient bit per cycle, over
// NUM_W = max(PIXEL_BITS + 2, 14) + 31 bits (45 at the default PIXEL_BITS);
// each iteration then runs on the single shared multiplier. busy drops in
// the done cycle, so the next pixel may follow at once. Write configuration
// only while busy is low.
module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int MAX_ITERATIONS = 10,
    parameter int PIXEL_BITS     = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIXEL_BITS-1:0] pixel_x,
    input  logic [PIXEL_BITS-1:0] pixel_y,
    output logic                  done,
    output logic [ESC_W-1:0]      escape_index,
    output logic [RED_W-1:0]      red_level
);

    localparam int DIFF_W = (PIXEL_BITS + 2 > DIM_W + 1) ? PIXEL_BITS + 2 : DIM_W + 1;
    localparam int NUM_W  = DIFF_W + SPAN_W;
    localparam int DEN_W  = DIM_W + 1;
    localparam int X_W    = NUM_W + 2;
    localparam int K_W    = $clog2(MAX_ITERATIONS + 1);
    localparam int RF_W   = (K_W + 3 > RED_W + 1) ? K_W + 3 : RED_W + 1;
    localparam int IX_W   = K_W + ESC_W;

    localparam logic signed [X_W-1:0] X_HI = X_W'(X_LIM);
    localparam logic signed [X_W-1:0] X_LO = -X_HI;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MAP_MUL  = 12'b0000_0000_0010,
        ST_MAP_DSET = 12'b0000_0000_0100,
        ST_MAP_DIV  = 12'b0000_0000_1000,
        ST_MAP_ADD  = 12'b0000_0001_0000,
        ST_C_PREP   = 12'b0000_0010_0000,
        ST_C_MUL    = 12'b0000_0100_0000,
        ST_C_SET    = 12'b0000_1000_0000,
        ST_Z_RR     = 12'b0001_0000_0000,
        ST_Z_II     = 12'b0010_0000_0000,
        ST_Z_CHK    = 12'b0100_0000_0000,
        ST_Z_UPD    = 12'b1000_0000_0000
    } state_t;

    cfg_t cfg;

    // control state
    state_t            state_reg;
    state_t            state_next;
    logic              axis_reg;
    logic              axis_next;
    logic [K_W-1:0]    k_reg;
    logic [K_W-1:0]    k_next;
    logic              done_reg;
    logic              done_next;

    // payload
    logic [PIXEL_BITS-1:0] px_reg;
    logic [PIXEL_BITS-1:0] px_next;
    logic [PIXEL_BITS-1:0] py_reg;
    logic [PIXEL_BITS-1:0] py_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic signed [XC_W-1:0] xc_reg;
    logic signed [XC_W-1:0] xc_next;
    logic                  sgn_reg;
    logic                  sgn_next;
    logic [N_W-1:0]        n_reg;
    logic [N_W-1:0]        n_next;
    logic signed [Z_W-1:0] cr_reg;
    logic signed [Z_W-1:0] cr_next;
    logic signed [Z_W-1:0] ci_reg;
    logic signed [Z_W-1:0] ci_next;
    logic signed [Z_W-1:0] re_reg;
    logic signed [Z_W-1:0] re_next;
    logic signed [Z_W-1:0] im_reg;
    logic signed [Z_W-1:0] im_next;
    logic signed [PROD_W-1:0] rr_reg;
    logic signed [PROD_W-1:0] rr_next;
    logic signed [PROD_W-1:0] ii_reg;
    logic signed [PROD_W-1:0] ii_next;
    logic [ESC_W-1:0]      esc_reg;
    logic [ESC_W-1:0]      esc_next;
    logic [RED_W-1:0]      red_reg;
    logic [RED_W-1:0]      red_next;

    // shared units
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [NUM_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;

    // datapath temporaries
    logic [PIXEL_BITS-1:0]    pix;
    logic [DIM_W-1:0]         dim_raw;
    logic [DIM_W-1:0]         dim_eff;
    logic [SPAN_W-1:0]        span;
    logic [CENTER_W-1:0]      center;
    logic signed [DIFF_W-1:0] diff;
    logic [DEN_W-1:0]         den;
    logic [DEN_W-1:0]         den_m1;
    logic                     prod_neg;
    logic [PROD_W-1:0]        prod_mag;
    logic                     sub_q;
    logic signed [X_W-1:0]    cx;
    logic signed [X_W-1:0]    qx;
    logic signed [X_W-1:0]    x_sum;
    logic signed [X_W-1:0]    x_clamp;
    logic [XC_W-1:0]          x_mag;
    logic [Q_W-1:0]           q_c;
    logic signed [Z_W-1:0]    q_s;
    logic signed [Z_W-1:0]    c_val;
    logic signed [Z_W-1:0]    c_sat;
    logic signed [PROD_W-1:0] mag2;
    logic                     escaped;
    logic signed [PROD_W-1:0] re_sh;
    logic signed [PROD_W-1:0] im_sh;
    logic [K_W-1:0]           idx_m1;
    logic [IX_W-1:0]          idx_ext;
    logic [RF_W-1:0]          red_full;
    logic [RED_W-1:0]         red_esc;

    mep_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mep_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mep_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // axis-selected operands and per-state arithmetic
    always_comb
    begin
        pix     = axis_reg ? py_reg : px_reg;
        dim_raw = axis_reg ? cfg.image_height : cfg.image_width;
        span    = axis_reg ? cfg.span_y : cfg.span_x;
        center  = axis_reg ? cfg.center_y : cfg.center_x;
        dim_eff = (dim_raw == '0) ? DIM_W'(1) : dim_raw;
        diff    = DIFF_W'({pix, 1'b0}) - DIFF_W'(dim_eff);
        den     = {dim_eff, 1'b0};
        den_m1  = den - DEN_W'(1);

        // floor of a negative quotient: divide |n| + d - 1, then negate
        prod_neg = prod[PROD_W-1];
        prod_mag = prod_neg ? PROD_W'(-prod) : PROD_W'(prod);
        div_num  = prod_mag[NUM_W-1:0] + (prod_neg ? NUM_W'(den_m1) : '0);
        div_den  = den;

        // y runs downward: subtract the offset there
        sub_q   = neg_reg ^ axis_reg;
        cx      = X_W'($signed(center));
        qx      = X_W'(div_quo);
        x_sum   = sub_q ? (cx - qx) : (cx + qx);
        if (x_sum > X_HI)
        begin
            x_clamp = X_HI;
        end
        else if (x_sum < X_LO)
        begin
            x_clamp = X_LO;
        end
        else
        begin
            x_clamp = x_sum;
        end

        x_mag = xc_reg[XC_W-1] ? XC_W'(-xc_reg) : XC_W'(xc_reg);

        q_c   = prod[RECIP_SHIFT +: Q_W];
        q_s   = Z_W'(q_c);
        c_val = sgn_reg ? -q_s : q_s;
        if (c_val > C_HI)
        begin
            c_sat = C_HI;
        end
        else if (c_val < C_LO)
        begin
            c_sat = C_LO;
        end
        else
        begin
            c_sat = c_val;
        end

        mag2    = rr_reg + prod;
        escaped = (k_reg != '0) && (mag2 > ESC_BOUND);

        re_sh = (rr_reg - ii_reg) >>> Z_FRAC;
        im_sh = prod >>> (Z_FRAC - 1);

        // index and red level of an escape at the previous update
        idx_m1   = k_reg - K_W'(1);
        idx_ext  = IX_W'(idx_m1);
        red_full = (RF_W'(idx_m1) << 2) + RF_W'(idx_m1);
        red_esc  = (red_full > RF_W'(RED_MAX)) ? RED_MAX : red_full[RED_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        px_next    = px_reg;
        py_next    = py_reg;
        neg_next   = neg_reg;
        xc_next    = xc_reg;
        sgn_next   = sgn_reg;
        n_next     = n_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        esc_next   = esc_reg;
        red_next   = red_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    axis_next  = 1'b0;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                mul_a      = MUL_W'(diff);
                mul_b      = MUL_W'($signed({1'b0, span}));
                state_next = ST_MAP_DSET;
            end
            ST_MAP_DSET:
            begin
                neg_next   = prod_neg;
                div_start  = 1'b1;
                state_next = ST_MAP_DIV;
            end
            ST_MAP_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MAP_ADD;
                end
            end
            ST_MAP_ADD:
            begin
                xc_next    = x_clamp[XC_W-1:0];
                state_next = ST_C_PREP;
            end
            ST_C_PREP:
            begin
                sgn_next   = xc_reg[XC_W-1];
                n_next     = {x_mag, X_TO_C_SHIFT'(0)}
                             + (xc_reg[XC_W-1] ? N_W'(RECIP_BIAS) : '0);
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                // divide by 3 through the reciprocal
                mul_a      = MUL_W'(n_reg);
                mul_b      = RECIP_MUL;
                state_next = ST_C_SET;
            end
            ST_C_SET:
            begin
                if (!axis_reg)
                begin
                    cr_next    = c_sat;
                    axis_next  = 1'b1;
                    state_next = ST_MAP_MUL;
                end
                else
                begin
                    ci_next    = c_sat;
                    re_next    = '0;
                    im_next    = '0;
                    k_next     = '0;
                    state_next = ST_Z_RR;
                end
            end
            ST_Z_RR:
            begin
                mul_a      = MUL_W'(re_reg);
                mul_b      = MUL_W'(re_reg);
                state_next = ST_Z_II;
            end
            ST_Z_II:
            begin
                rr_next    = prod;
                mul_a      = MUL_W'(im_reg);
                mul_b      = MUL_W'(im_reg);
                state_next = ST_Z_CHK;
            end
            ST_Z_CHK:
            begin
                ii_next = prod;
                mul_a   = MUL_W'(re_reg);
                mul_b   = MUL_W'(im_reg);
                if (escaped)
                begin
                    esc_next   = idx_ext[ESC_W-1:0];
                    red_next   = red_esc;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (k_reg == K_W'(MAX_ITERATIONS))
                begin
                    esc_next   = '0;
                    red_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_Z_UPD;
                end
            end
            ST_Z_UPD:
            begin
                re_next    = re_sh[Z_W-1:0] + cr_reg;
                im_next    = im_sh[Z_W-1:0] + ci_reg;
                k_next     = k_reg + K_W'(1);
                state_next = ST_Z_RR;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        neg_reg <= neg_next;
        xc_reg  <= xc_next;
        sgn_reg <= sgn_next;
        n_reg   <= n_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
        re_reg  <= re_next;
        im_reg  <= im_next;
        rr_reg  <= rr_next;
        ii_reg  <= ii_next;
        esc_reg <= esc_next;
        red_reg <= red_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign escape_index = esc_reg;
    assign red_level    = red_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while sequencer still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted pixel did not start the sequencer");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_Z_CHK))
        else $error("result strobed outside the escape check");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_W'(MAX_ITERATIONS))
        else $error("iteration count past the limit");

    a_c_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Z_RR) |-> (cr_reg <= C_HI && cr_reg >= C_LO
                                    && ci_reg <= C_HI && ci_reg >= C_LO))
        else $error("c outside the saturation range");

endmodule
